// ----- hw/rtl/iss_pkg.sv -----
package iss_pkg;

	localparam int DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int TAG_W = 16;
	localparam int DATA_W = KEY_W + TAG_W;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	// Broadcast control shared by every cell of the chain.
	typedef struct packed {
		logic             ins;
		logic             pop;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} ctrl_t;

endpackage

// ----- hw/rtl/iss_cell.sv -----
module iss_cell
	import iss_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  ctrl_t ctrl,
	input  rec_t  prev_rec,
	input  logic  prev_keep,
	input  rec_t  next_rec,
	output rec_t  rec,
	output logic  keep
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [TAG_W-1:0] tag_q;
	rec_t             ins_rec;

	assign rec = '{valid: valid_q, key: key_q, tag: tag_q};

	// A record stays in place while its key is strictly below the new key, so a new
	// record lands in front of older records with an equal key.
	assign keep = valid_q && (key_q < ctrl.key);

	always_comb begin
		if (prev_keep) begin
			ins_rec = '{valid: 1'b1, key: ctrl.key, tag: ctrl.tag};
		end else begin
			ins_rec = prev_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_rec.valid;
		end else if (ctrl.ins && !keep) begin
			valid_q <= ins_rec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			key_q <= next_rec.key;
			tag_q <= next_rec.tag;
		end else if (ctrl.ins && !keep) begin
			key_q <= ins_rec.key;
			tag_q <= ins_rec.tag;
		end
	end

endmodule

// ----- hw/rtl/insertion_sort_by_key.sv -----
// Latency: a record is written into the cell chain at the edge of its transfer, unless the
// chain is full, and is in place in the next cycle; the first sorted result is offered in
// the cycle after the last record is taken.
// Throughput: one record per cycle while collecting, set by the compare and shift in the
// cell chain; the drain gives one result per cycle while m_tready holds and takes no input.
// Reset clears the valid bit of every cell and the overflow flag; cell payload is not reset.
module insertion_sort_by_key
	import iss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // key [31:0], tag [47:32]
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // sorted_key [31:0], sorted_tag [47:32]
	output logic              m_tlast,
	output logic              m_tuser    // overflowed
);

	logic             draining_q;
	logic             drop_q;
	logic             s_xfer;
	logic             m_xfer;
	logic             full;
	ctrl_t            ctrl;
	rec_t             cell_rec  [DEPTH];
	logic [DEPTH-1:0] cell_keep;
	logic [DEPTH-1:0] valid_vec;

	assign s_tready = !draining_q;
	assign s_xfer   = s_tvalid && s_tready;
	assign full     = cell_rec[DEPTH-1].valid;

	assign m_tvalid = draining_q && cell_rec[0].valid;
	assign m_xfer   = m_tvalid && m_tready;
	assign m_tdata  = {cell_rec[0].tag, cell_rec[0].key};
	assign m_tlast  = !cell_rec[1].valid;
	assign m_tuser  = drop_q;

	assign ctrl = '{
		ins: s_xfer && !full,
		pop: m_xfer,
		key: s_tdata[KEY_W-1:0],
		tag: s_tdata[DATA_W-1:KEY_W]
	};

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			rec_t prev_rec;
			rec_t next_rec;
			logic prev_keep;

			assign valid_vec[gi] = cell_rec[gi].valid;

			if (gi == 0) begin : g_head
				assign prev_rec  = '0;
				assign prev_keep = 1'b1;
			end else begin : g_body
				assign prev_rec  = cell_rec[gi-1];
				assign prev_keep = cell_keep[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign next_rec = '0;
			end else begin : g_inner
				assign next_rec = cell_rec[gi+1];
			end

			iss_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.prev_rec  (prev_rec),
				.prev_keep (prev_keep),
				.next_rec  (next_rec),
				.rec       (cell_rec[gi]),
				.keep      (cell_keep[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			drop_q     <= 1'b0;
		end else begin
			if (s_xfer && full) begin
				drop_q <= 1'b1;
			end else if (m_xfer && m_tlast) begin
				drop_q <= 1'b0;
			end
			if (s_xfer && s_tlast) begin
				draining_q <= 1'b1;
			end else if (m_xfer && m_tlast) begin
				draining_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// Occupied cells always form a prefix of the chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(valid_vec ^ (valid_vec >> 1)))
	else $error("cell valid bits are not a contiguous prefix");

	// The two leading cells stay in ascending key order.
	assert property (@(posedge clk) disable iff (!arst_n)
		cell_rec[1].valid |-> (cell_rec[0].key <= cell_rec[1].key))
	else $error("leading cells out of key order");

	// After the final result the block takes records again and the store is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_xfer && m_tlast) |=> (s_tready && !cell_rec[0].valid && !m_tuser))
	else $error("store not released after final result");

	// The overflow flag holds over the whole drain.
	assert property (@(posedge clk) disable iff (!arst_n)
		(draining_q && $past(draining_q)) |-> $stable(m_tuser))
	else $error("overflow flag changed during drain");
`endif

endmodule
